@@ sv/timed_output_step_sequencer_top_defines.svh @@
// Assertion macros for the timed output step sequencer.
// Included by the top level; expects i_clk and i_rst_n in the including scope.
`ifndef TIMED_OUTPUT_STEP_SEQUENCER_TOP_DEFINES_SVH
`define TIMED_OUTPUT_STEP_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TOS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TOS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/tos_pkg.sv @@
// Shared constants, codes and types for the timed output step sequencer.
// No dependencies; used by tos_core and timed_output_step_sequencer_top.
`default_nettype none

package tos_pkg;

    localparam int NUM_SLOTS    = 8;
    localparam int MAX_STEPS    = 32;
    localparam int NUM_CHANNELS = 8;

    localparam int STORE_DEPTH = NUM_SLOTS * MAX_STEPS;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int SLOT_IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int LEN_W       = $clog2(MAX_STEPS + 1);
    localparam int ENTRY_W     = 20;

    localparam logic [15:0] GUARD_RESET_MS = 16'd1000;

    // Command codes carried in the input tuser.
    localparam logic [2:0] CMD_TICK    = 3'd0;
    localparam logic [2:0] CMD_WRITE   = 3'd1;
    localparam logic [2:0] CMD_SET_LEN = 3'd2;
    localparam logic [2:0] CMD_START   = 3'd3;
    localparam logic [2:0] CMD_STOP    = 3'd4;

    // Action codes carried in the output tuser.
    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_SET   = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // Start answer codes.
    localparam logic [1:0] ST_NONE     = 2'd0;
    localparam logic [1:0] ST_ACCEPTED = 2'd1;
    localparam logic [1:0] ST_GUARD    = 2'd2;
    localparam logic [1:0] ST_UNDEF    = 2'd3;

    typedef logic [ADDR_W-1:0]     t_addr;
    typedef logic [SLOT_IDX_W-1:0] t_sidx;
    typedef logic [LEN_W-1:0]      t_len;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [2:0]  slot;
        logic [5:0]  step_index;
        logic [2:0]  channel;
        logic        drive_low;
        logic [15:0] duration_ms;
    } t_item;

    typedef struct packed {
        logic [1:0] action;
        logic [2:0] out_channel;
        logic       out_drive_low;
        logic [1:0] start_status;
        logic       running;
        logic [5:0] current_step;
    } t_result;

    typedef struct packed {
        logic accept;
        logic commit;
    } t_ctl;

    function automatic t_addr step_addr(input logic [2:0] slot, input logic [5:0] idx);
        return t_addr'(int'(slot) * MAX_STEPS + int'(idx));
    endfunction

endpackage

`default_nettype wire

@@ sv/tos_core.sv @@
// Sequencer state and step memory: reads the step store when an item is
// accepted and commits the item when i_ctl.commit is raised. Depends on tos_pkg.
`default_nettype none

module tos_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire tos_pkg::t_ctl    i_ctl,
    input  wire tos_pkg::t_item   i_item,
    input  wire logic [15:0]      i_guard_ms,
    output tos_pkg::t_result      o_result
);
    import tos_pkg::*;

    logic [ENTRY_W-1:0] r_store [STORE_DEPTH];
    logic [ENTRY_W-1:0] r_rdata;
    t_item              r_item;

    t_len        r_len [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_def;
    t_sidx       r_active;
    logic [5:0]  r_pidx;
    logic        r_run;
    logic        r_started;
    logic [31:0] r_sst;
    logic [31:0] r_time;
    logic [31:0] r_last;
    logic        r_first;

    t_sidx       n_active;
    logic [5:0]  n_pidx;
    logic        n_run;
    logic        n_started;
    logic [31:0] n_sst;
    logic [31:0] n_time;
    logic [31:0] n_last;
    logic        n_first;

    logic        w_we;
    logic        w_len_we;
    t_len        w_new_len;
    t_sidx       w_slot_idx;
    t_len        w_cur_len;
    logic [31:0] w_elapsed;
    logic        w_slot_ok;
    t_result     w_res;

    assign w_slot_idx = t_sidx'(r_item.slot);
    assign w_slot_ok  = int'(r_item.slot) < NUM_SLOTS;
    assign w_cur_len  = r_len[r_active];
    assign w_we       = i_ctl.commit && (r_item.cmd == CMD_WRITE) && w_slot_ok
                        && (int'(r_item.step_index) < MAX_STEPS)
                        && (int'(r_item.channel) < NUM_CHANNELS);
    assign w_len_we   = i_ctl.commit && (r_item.cmd == CMD_SET_LEN) && w_slot_ok;
    assign w_new_len  = (int'(r_item.step_index) > MAX_STEPS) ? t_len'(MAX_STEPS)
                                                              : t_len'(r_item.step_index);

    // Step store: written on commit, read on accept with the playing position.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_store[step_addr(r_item.slot, r_item.step_index)] <=
                {r_item.channel, r_item.drive_low, r_item.duration_ms};
        end
        if (i_ctl.accept) begin
            r_rdata <= r_store[step_addr(r_active, r_pidx)];
            r_item  <= i_item;
        end
    end

    always_comb begin
        n_active  = r_active;
        n_pidx    = r_pidx;
        n_run     = r_run;
        n_started = r_started;
        n_sst     = r_sst;
        n_time    = r_time;
        n_last    = r_last;
        n_first   = r_first;
        w_elapsed = '0;
        w_res     = '0;
        unique case (r_item.cmd)
            CMD_TICK: begin
                n_time = r_time + 32'd1;
                if (r_run) begin
                    if ((int'(r_pidx) >= int'(w_cur_len)) || (int'(r_pidx) >= MAX_STEPS)) begin
                        n_run        = 1'b0;
                        w_res.action = ACT_CLEAR;
                    end else begin
                        if (!r_started) begin
                            w_res.action        = ACT_SET;
                            w_res.out_channel   = r_rdata[19:17];
                            w_res.out_drive_low = r_rdata[16];
                            n_started           = 1'b1;
                            n_sst               = n_time;
                        end else begin
                            w_elapsed = n_time - r_sst;
                        end
                        if (w_elapsed >= {16'd0, r_rdata[15:0]}) begin
                            n_pidx    = r_pidx + 6'd1;
                            n_started = 1'b0;
                        end
                    end
                end
            end
            CMD_START: begin
                if (!(((r_time - r_last) > {16'd0, i_guard_ms}) || r_first)) begin
                    w_res.start_status = ST_GUARD;
                end else if (!w_slot_ok || !r_def[w_slot_idx]) begin
                    w_res.start_status = ST_UNDEF;
                end else begin
                    w_res.start_status = ST_ACCEPTED;
                    n_active  = w_slot_idx;
                    n_pidx    = '0;
                    n_run     = 1'b1;
                    n_first   = 1'b0;
                    n_last    = r_time;
                    n_started = 1'b0;
                end
            end
            CMD_STOP: begin
                n_run        = 1'b0;
                w_res.action = ACT_CLEAR;
            end
            default: begin
                // Writes and length changes only touch the stores; others do nothing.
            end
        endcase
        w_res.running      = n_run;
        w_res.current_step = n_pidx;
    end

    assign o_result = w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_len[i] <= '0;
            end
            r_def     <= '0;
            r_active  <= '0;
            r_pidx    <= '0;
            r_run     <= 1'b0;
            r_started <= 1'b0;
            r_sst     <= '0;
            r_time    <= '0;
            r_last    <= '0;
            r_first   <= 1'b1;
        end else if (i_ctl.commit) begin
            if (w_len_we) begin
                r_len[w_slot_idx] <= w_new_len;
                r_def[w_slot_idx] <= 1'b1;
            end
            r_active  <= n_active;
            r_pidx    <= n_pidx;
            r_run     <= n_run;
            r_started <= n_started;
            r_sst     <= n_sst;
            r_time    <= n_time;
            r_last    <= n_last;
            r_first   <= n_first;
        end
    end

endmodule

`default_nettype wire

@@ sv/timed_output_step_sequencer_top.sv @@
// Top level of the timed output step sequencer: stream ports, guard register,
// output register and assertions. Depends on tos_pkg, tos_core and the defines header.
//
// Usage:
// The slave stream carries one command per beat: tuser holds the command
// (tick of 1 ms, write step, set length, start, stop) and tdata the slot, step
// index, channel, level and duration. Every input beat produces exactly one
// result beat on the master stream: tuser holds the output action (nothing,
// set one channel, clear all outputs) and tdata the channel, level, start
// answer, running flag and playing step index.
// Each beat is handled in turn: the accept cycle reads the step store, a
// synchronous memory, and the commit cycle, once the result register is free,
// updates the state and loads the result register. A new beat is accepted
// only after the previous beat has been committed.
// The result register decouples the sides: the next input beat is taken while
// a result waits. If the receiver keeps tready low, the following result holds
// in the core and s_axis_tready stays low until the register frees up.
// Reset (synchronous, active low) stops playback, clears all slot lengths and
// definitions, zeroes the millisecond counter, sets the guard period to 1000 ms
// and arms the first start. Step store contents are kept and are undefined
// until written. The guard period is written through i_cfg_we and i_cfg_wdata.
`default_nettype none

`include "timed_output_step_sequencer_top_defines.svh"

module timed_output_step_sequencer_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,     // guard_period_ms
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [2:0] slot, [8:3] step_index, [11:9] channel, [12] drive_low,
    // [28:13] duration_ms, [31:29] zero
    input  wire logic [31:0] s_axis_tdata,
    input  wire logic [2:0]  s_axis_tuser,    // [2:0] command
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [2:0] out_channel, [3] out_drive_low, [5:4] start_status, [6] running,
    // [12:7] current_step, [15:13] zero
    output logic [15:0]      m_axis_tdata,
    output logic [1:0]       m_axis_tuser     // [1:0] action
);
    import tos_pkg::*;

    logic             r_busy;
    logic             r_out_valid;
    tos_pkg::t_result r_out;
    logic [15:0]      r_guard;

    t_ctl    w_ctl;
    t_item   w_item;
    t_result w_res;

    // One beat in flight at a time; the commit waits for a free result register.
    assign w_ctl.accept = s_axis_tvalid && !r_busy;
    assign w_ctl.commit = r_busy && (!r_out_valid || m_axis_tready);

    assign w_item.cmd         = s_axis_tuser;
    assign w_item.slot        = s_axis_tdata[2:0];
    assign w_item.step_index  = s_axis_tdata[8:3];
    assign w_item.channel     = s_axis_tdata[11:9];
    assign w_item.drive_low   = s_axis_tdata[12];
    assign w_item.duration_ms = s_axis_tdata[28:13];

    tos_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_item     (w_item),
        .i_guard_ms (r_guard),
        .o_result   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_guard     <= GUARD_RESET_MS;
        end else begin
            if (w_ctl.accept) begin
                r_busy <= 1'b1;
            end else if (w_ctl.commit) begin
                r_busy <= 1'b0;
            end
            if (w_ctl.commit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_guard <= i_cfg_wdata;
            end
        end
    end

    // Result payload needs no reset; it is qualified by r_out_valid.
    always_ff @(posedge i_clk) begin
        if (w_ctl.commit) begin
            r_out <= w_res;
        end
    end

    assign s_axis_tready = !r_busy;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.action;
    assign m_axis_tdata  = {3'b000, r_out.current_step, r_out.running, r_out.start_status,
                            r_out.out_drive_low, r_out.out_channel};

    // A result that does not set a channel carries no channel or level.
    `TOS_ASSERT_IMP(a_idle_fields_zero, r_out_valid && (r_out.action != ACT_SET), (r_out.out_channel == 3'd0) && !r_out.out_drive_low, "channel fields set without a set action")
    // An accepted start always leaves playback running from the first step.
    `TOS_ASSERT_IMP(a_start_runs, r_out_valid && (r_out.start_status == ST_ACCEPTED), r_out.running && (r_out.current_step == 6'd0), "accepted start did not begin playback")
    // Clearing all outputs always ends playback.
    `TOS_ASSERT_IMP(a_clear_stops, r_out_valid && (r_out.action == ACT_CLEAR), !r_out.running, "clear issued while still running")
    // An accepted beat is held in work until its result is committed.
    `TOS_ASSERT_NXT(a_accept_busy, s_axis_tvalid && s_axis_tready, r_busy && !s_axis_tready, "accepted beat not held in work")

endmodule

`default_nettype wire
